// ===== hw/rtl/pts_pkg.sv =====
// Package for the periodic timer scheduler: field structs, command codes,
// controller/datapath interface types and sizing constants. No dependencies.
package pts_pkg;

    localparam int TimerSlots = 32;
    localparam int SlotW      = $clog2(TimerSlots);
    localparam int MaxFires   = 63;
    localparam int FireW      = $clog2(MaxFires + 1);

    localparam logic [15:0] DefaultWaitRst = 16'd1000;
    localparam logic [15:0] MinWaitRst     = 16'd10;
    localparam logic [15:0] LateLimitRst   = 16'd1000;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_CANCEL  = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_DEFAULT_WAIT = 2'd0,
        REG_MIN_WAIT     = 2'd1,
        REG_LATE_LIMIT   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  slot_id;
        logic [47:0] tick_value;
        logic [31:0] period;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  timer_slot;
        logic [47:0] fire_tick;
        logic [31:0] next_wait;
        logic        table_full;
        logic        more_due;
        logic        last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic scan_clr;   // start a new scan
        logic scan_step;  // examine one slot
        logic do_create;
        logic do_cancel;
        logic do_fire;    // act on the scan winner
        logic emit_ack;
        logic emit_fire;
        logic emit_done;
        logic set_more;
    } pts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       scan_end;   // last slot examined
        logic       found;      // a winner exists
        logic       due;        // winner deadline <= now
        logic       silenced;   // winner silenced
        logic       limit;      // fire count reached limit
        logic       out_busy;   // output register holds a result not taken
    } pts_sts_t;

endpackage

// ===== hw/rtl/pts_datapath.sv =====
// Datapath of the timer scheduler: slot table, sequential earliest-deadline scan,
// fire/re-arm arithmetic and the output register. Depends on pts_pkg.
module pts_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  pts_pkg::in_item_t  s_item,
    input  pts_pkg::pts_cmd_t  cmd,
    output pts_pkg::pts_sts_t  sts,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pts_pkg::out_item_t m_item
);
    import pts_pkg::*;

    logic [15:0] default_wait_reg, min_wait_reg, late_limit_reg;
    logic [TimerSlots-1:0] valid_reg;
    logic [TimerSlots-1:0] silenced_reg;
    logic [47:0] deadline_reg [TimerSlots];
    logic [31:0] period_reg [TimerSlots];

    in_item_t    req_reg;
    logic [SlotW-1:0] idx_reg;
    logic [SlotW-1:0] best_reg;
    logic             found_reg;
    logic [47:0]      best_dl_reg;
    logic [FireW-1:0] fires_reg;
    logic             more_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;
    out_item_t        out_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_wait_reg <= DefaultWaitRst;
            min_wait_reg     <= MinWaitRst;
            late_limit_reg   <= LateLimitRst;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_DEFAULT_WAIT: default_wait_reg <= cfg_data;
                REG_MIN_WAIT:     min_wait_reg     <= cfg_data;
                REG_LATE_LIMIT:   late_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // lowest free slot
    logic             free_any;
    logic [SlotW-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TimerSlots - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SlotW'(i);
            end
        end
    end

    // scan candidate compare
    logic [47:0] cand_dl;
    logic        cand_better;
    assign cand_dl     = deadline_reg[idx_reg];
    assign cand_better = valid_reg[idx_reg] && (!found_reg || cand_dl < best_dl_reg);

    // firing arithmetic on the winner
    logic [48:0] late_sum;
    logic        late;
    logic [47:0] ft;
    logic [48:0] nd_sum;
    logic [47:0] nd;
    logic [31:0] win_per;
    assign late_sum = {1'b0, best_dl_reg} + 49'(late_limit_reg);
    assign late     = late_sum < {1'b0, req_reg.tick_value};
    assign ft       = late ? req_reg.tick_value : best_dl_reg;
    assign win_per  = period_reg[best_reg];
    assign nd_sum   = {1'b0, ft} + 49'(win_per);
    assign nd       = nd_sum[48] ? '1 : nd_sum[47:0];

    // final wait
    logic [47:0] diff;
    logic [31:0] wait_raw, wait_fin;
    assign diff = best_dl_reg - req_reg.tick_value;
    always_comb begin
        if (!found_reg) wait_raw = 32'(default_wait_reg);
        else if (best_dl_reg > req_reg.tick_value)
            wait_raw = (diff[47:32] != '0) ? '1 : diff[31:0];
        else wait_raw = '0;
        wait_fin = (more_reg || wait_raw < 32'(min_wait_reg)) ? 32'(min_wait_reg)
                                                              : wait_raw;
    end

    // next result
    always_comb begin
        out_next = out_reg;
        if (cmd.emit_ack) begin
            out_next      = '0;
            out_next.last = 1'b1;
            if (req_reg.command == CMD_CREATE) begin
                out_next.kind       = KIND_CREATE;
                out_next.timer_slot = free_any ? 5'(free_idx) : 5'd0;
                out_next.table_full = !free_any;
            end else begin
                out_next.kind       = KIND_CANCEL;
                out_next.timer_slot = req_reg.slot_id;
            end
        end
        if (cmd.emit_fire) begin
            out_next            = '0;
            out_next.kind       = KIND_FIRED;
            out_next.timer_slot = 5'(best_reg);
            out_next.fire_tick  = ft;
        end
        if (cmd.emit_done) begin
            out_next           = '0;
            out_next.kind      = KIND_DONE;
            out_next.next_wait = wait_fin;
            out_next.more_due  = more_reg;
            out_next.last      = 1'b1;
        end
    end

    // control-bearing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            fires_reg     <= '0;
            more_reg      <= 1'b0;
        end else begin
            if (cmd.emit_ack || cmd.emit_fire || cmd.emit_done) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            if (cmd.load) begin
                fires_reg <= '0;
                more_reg  <= 1'b0;
            end
            if (cmd.scan_clr) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (cand_better) found_reg <= 1'b1;
            end
            if (cmd.set_more) more_reg <= 1'b1;
            if (cmd.do_create && free_any) valid_reg[free_idx] <= 1'b1;
            if (cmd.do_fire) begin
                if (silenced_reg[best_reg] || win_per == '0) valid_reg[best_reg] <= 1'b0;
                if (!silenced_reg[best_reg]) fires_reg <= fires_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= s_item;
        if (cmd.scan_step && cand_better) begin
            best_reg    <= idx_reg;
            best_dl_reg <= cand_dl;
        end
        if (cmd.do_create && free_any) begin
            deadline_reg[free_idx] <= req_reg.tick_value;
            period_reg[free_idx]   <= req_reg.period;
            silenced_reg[free_idx] <= 1'b0;
        end
        if (cmd.do_cancel && valid_reg[req_reg.slot_id[SlotW-1:0]]) begin
            silenced_reg[req_reg.slot_id[SlotW-1:0]] <= 1'b1;
            period_reg[req_reg.slot_id[SlotW-1:0]]   <= '0;
        end
        if (cmd.do_fire && !silenced_reg[best_reg] && win_per != '0)
            deadline_reg[best_reg] <= nd;
        out_reg <= out_next;
    end

    assign sts.command  = req_reg.command;
    assign sts.scan_end = (idx_reg == SlotW'(TimerSlots - 1));
    assign sts.found    = found_reg;
    assign sts.due      = best_dl_reg <= req_reg.tick_value;
    assign sts.silenced = silenced_reg[best_reg];
    assign sts.limit    = (fires_reg >= FireW'(MaxFires));
    assign sts.out_busy = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;
endmodule

// ===== hw/rtl/pts_ctrl.sv =====
// Controller state machine of the timer scheduler: sequences commands, scans
// and result emission. Depends on pts_pkg.
module pts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output pts_pkg::pts_cmd_t cmd,
    input  pts_pkg::pts_sts_t sts
);
    import pts_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_FIRE   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.out_busy) begin
                    case (cmd_t'(sts.command))
                        CMD_CREATE: begin
                            cmd.do_create = 1'b1;
                            cmd.emit_ack  = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        CMD_CANCEL: begin
                            cmd.do_cancel = 1'b1;
                            cmd.emit_ack  = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        CMD_ADVANCE: begin
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            // one slot per cycle
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!sts.found || !sts.due) state_next = ST_DONE;
                else if (sts.limit) begin
                    cmd.set_more = 1'b1;
                    state_next   = ST_DONE;
                end else state_next = ST_FIRE;
            end
            ST_FIRE: begin
                if (sts.silenced) begin
                    cmd.do_fire  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end else if (!sts.out_busy) begin
                    cmd.do_fire   = 1'b1;
                    cmd.emit_fire = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end
endmodule

// ===== hw/rtl/periodic_timer_scheduler.sv =====
// Top level of the periodic timer scheduler: controller plus datapath.
// Depends on pts_pkg, pts_ctrl, pts_datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------
//  input    | s_valid / s_ready  | s_item (in_item_t)
//  result   | m_valid / m_ready  | m_item (out_item_t)
//  config   | cfg_we             | cfg_idx, cfg_data
//
// Create and cancel pass through decode, which waits for a free output. Advance
// runs a full deadline scan, one slot per cycle, for each due timer taken and once
// more for the final scan. One request at a time.
// Reset is synchronous, active low, and clears the slot valid bits at once.
// A stalled result channel holds the controller before the next result.
module periodic_timer_scheduler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pts_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output pts_pkg::out_item_t m_item,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [15:0]        cfg_data
);
    import pts_pkg::*;

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    pts_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );
endmodule

// ===== verif/tb_periodic_timer_scheduler.sv =====
// Self-checking testbench for periodic_timer_scheduler: directed and random
// create/cancel/advance requests against an in-bench timer table predictor.
// Depends on pts_pkg and the periodic_timer_scheduler RTL.
module tb_periodic_timer_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import pts_pkg::*;

    localparam int          CycleLimit = 3_000_000;
    localparam logic [47:0] TickMax    = 48'hFFFF_FFFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    periodic_timer_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // predicted timer table and registers
    logic        tmr_live [TimerSlots];
    logic [47:0] tmr_deadline [TimerSlots];
    logic [31:0] tmr_period [TimerSlots];
    logic        tmr_silenced [TimerSlots];
    logic [15:0] dflt_wait_q = DefaultWaitRst;
    logic [15:0] min_wait_q = MinWaitRst;
    logic [15:0] late_limit_q = LateLimitRst;

    out_item_t   pending_results[$];
    int          err_count = 0;
    int          cycle_count = 0;
    logic        rx_hold = 1'b0;
    logic [47:0] sim_now = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_periodic_timer_scheduler failed");
            $finish;
        end
    end

    function automatic out_item_t mk_result(kind_t k, logic [4:0] slot, logic [47:0] tick,
                                            logic [31:0] wt, logic full, logic more,
                                            logic lst);
        out_item_t r;
        r.kind = k;
        r.timer_slot = slot;
        r.fire_tick = tick;
        r.next_wait = wt;
        r.table_full = full;
        r.more_due = more;
        r.last = lst;
        return r;
    endfunction

    // earliest live timer, lower slot wins ties; -1 when the table is empty
    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int i = 0; i < TimerSlots; i++)
            if (tmr_live[i] && (best < 0 || tmr_deadline[i] < tmr_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic void predict_results(in_item_t it);
        int          e;
        int          fires;
        logic        more;
        logic        late;
        logic [63:0] ft;
        logic [63:0] nd;
        logic [63:0] wt;
        bit          placed;
        placed = 1'b0;
        fires = 0;
        more = 1'b0;
        case (cmd_t'(it.command))
            CMD_CREATE: begin
                for (int i = 0; i < TimerSlots && !placed; i++) begin
                    if (!tmr_live[i]) begin
                        tmr_live[i] = 1'b1;
                        tmr_deadline[i] = it.tick_value;
                        tmr_period[i] = it.period;
                        tmr_silenced[i] = 1'b0;
                        pending_results.push_back(mk_result(KIND_CREATE, 5'(i), 48'd0,
                                                            32'd0, 1'b0, 1'b0, 1'b1));
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    pending_results.push_back(mk_result(KIND_CREATE, 5'd0, 48'd0, 32'd0,
                                                        1'b1, 1'b0, 1'b1));
            end
            CMD_CANCEL: begin
                if (tmr_live[it.slot_id]) begin
                    tmr_silenced[it.slot_id] = 1'b1;
                    tmr_period[it.slot_id] = '0;
                end
                pending_results.push_back(mk_result(KIND_CANCEL, it.slot_id, 48'd0, 32'd0,
                                                    1'b0, 1'b0, 1'b1));
            end
            CMD_ADVANCE: begin
                while (1) begin
                    e = earliest_timer();
                    if (e < 0 || tmr_deadline[e] > it.tick_value)
                        break;
                    if (fires >= MaxFires) begin
                        more = 1'b1;
                        break;
                    end
                    late = (64'(tmr_deadline[e]) + 64'(late_limit_q)) < 64'(it.tick_value);
                    ft = late ? 64'(it.tick_value) : 64'(tmr_deadline[e]);
                    if (tmr_silenced[e]) begin
                        tmr_live[e] = 1'b0;
                        continue;
                    end
                    pending_results.push_back(mk_result(KIND_FIRED, 5'(e), ft[47:0], 32'd0,
                                                        1'b0, 1'b0, 1'b0));
                    fires++;
                    if (tmr_period[e] == 0) begin
                        tmr_live[e] = 1'b0;
                        continue;
                    end
                    nd = ft + 64'(tmr_period[e]);
                    tmr_deadline[e] = (nd > 64'(TickMax)) ? TickMax : nd[47:0];
                end
                if (e < 0)
                    wt = 64'(dflt_wait_q);
                else if (tmr_deadline[e] > it.tick_value) begin
                    wt = 64'(tmr_deadline[e]) - 64'(it.tick_value);
                    if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
                end else
                    wt = '0;
                if (wt < 64'(min_wait_q)) wt = 64'(min_wait_q);
                pending_results.push_back(mk_result(KIND_DONE, 5'd0, 48'd0, wt[31:0],
                                                    1'b0, more, 1'b1));
            end
            default: ;  // unknown command: no result
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: %p", m_item);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_item.kind !== exp_r.kind) begin
                    $error("kind: expected %0d actual %0d", exp_r.kind, m_item.kind);
                    err_count++;
                end
                if (m_item.timer_slot !== exp_r.timer_slot) begin
                    $error("timer_slot: expected %0d actual %0d",
                           exp_r.timer_slot, m_item.timer_slot);
                    err_count++;
                end
                if (m_item.fire_tick !== exp_r.fire_tick) begin
                    $error("fire_tick: expected %0d actual %0d",
                           exp_r.fire_tick, m_item.fire_tick);
                    err_count++;
                end
                if (m_item.next_wait !== exp_r.next_wait) begin
                    $error("next_wait: expected %0d actual %0d",
                           exp_r.next_wait, m_item.next_wait);
                    err_count++;
                end
                if (m_item.table_full !== exp_r.table_full) begin
                    $error("table_full: expected %0b actual %0b",
                           exp_r.table_full, m_item.table_full);
                    err_count++;
                end
                if (m_item.more_due !== exp_r.more_due) begin
                    $error("more_due: expected %0b actual %0b", exp_r.more_due, m_item.more_due);
                    err_count++;
                end
                if (m_item.last !== exp_r.last) begin
                    $error("last: expected %0b actual %0b", exp_r.last, m_item.last);
                    err_count++;
                end
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            if (rx_hold) begin
                m_ready <= 1'b0;
                while (rx_hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_request(cmd_t cmd, logic [4:0] slot, logic [47:0] tick,
                                logic [31:0] per);
        int       gap;
        in_item_t it;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        it.command = cmd;
        it.slot_id = slot;
        it.tick_value = tick;
        it.period = per;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        predict_results(it);
    endtask

    // stop offering and wait until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_DEFAULT_WAIT: dflt_wait_q = val;
            REG_MIN_WAIT:     min_wait_q = val;
            REG_LATE_LIMIT:   late_limit_q = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // silence every live slot, then sweep them all out
    task automatic clear_table();
        for (int i = 0; i < TimerSlots; i++)
            if (tmr_live[i]) send_request(CMD_CANCEL, 5'(i), '0, '0);
        send_request(CMD_ADVANCE, '0, TickMax, '0);
        wait_drained();
    endtask

    task automatic test_directed();
        send_request(CMD_ADVANCE, 5'd0, 48'd0, 32'd0);            // empty table
        send_request(CMD_CREATE, 5'd31, 48'd0, 32'd0);            // one-shot at 0
        send_request(CMD_CREATE, 5'd0, TickMax, 32'hFFFF_FFFF);   // far deadline
        send_request(CMD_CREATE, 5'd0, 48'd100, 32'd50);          // periodic
        send_request(CMD_CREATE, 5'd0, 48'd100, 32'd0);           // tie with slot 2
        send_request(CMD_CREATE, 5'd0, 48'd40, 32'd7);
        send_request(CMD_CANCEL, 5'd3, '0, '0);                   // cancel live timer
        send_request(CMD_CANCEL, 5'd3, '0, '0);                   // already silenced
        send_request(CMD_CANCEL, 5'd31, '0, '0);                  // free slot
        send_request(CMD_NONE, 5'd31, TickMax, 32'hFFFF_FFFF);    // ignored command
        send_request(CMD_ADVANCE, 5'd0, 48'd5, 32'd0);            // fires slot 0
        send_request(CMD_ADVANCE, 5'd0, 48'd100, 32'd0);          // ties, silenced drop
        send_request(CMD_ADVANCE, 5'd0, 48'd5000, 32'd0);         // very late
        send_request(CMD_CANCEL, 5'd4, '0, '0);
        send_request(CMD_ADVANCE, 5'd0, 48'd6000, 32'd0);
        send_request(CMD_ADVANCE, 5'd0, 48'hFFFF_FFFF_FFFE, 32'd0); // rearm saturates
        wait_drained();
        clear_table();
    endtask

    task automatic test_full_table();
        for (int i = 0; i <= TimerSlots; i++)
            send_request(CMD_CREATE, '0, 48'(1000 + i), 32'd0);
        send_request(CMD_ADVANCE, '0, 48'd1010, '0);
        send_request(CMD_CREATE, '0, 48'd1, 32'd3);
        wait_drained();
        clear_table();
    endtask

    // 32 fast periodic timers overrun the firing limit
    task automatic test_fire_limit();
        for (int i = 0; i < TimerSlots; i++) send_request(CMD_CREATE, '0, 48'(i % 3), 32'd1);
        send_request(CMD_ADVANCE, '0, 48'd500, '0);
        send_request(CMD_ADVANCE, '0, 48'd500, '0);
        wait_drained();
        clear_table();
    endtask

    task automatic test_registers();
        write_reg(REG_DEFAULT_WAIT, 16'd0);
        write_reg(REG_MIN_WAIT, 16'd0);
        write_reg(REG_LATE_LIMIT, 16'd0);
        send_request(CMD_ADVANCE, '0, 48'd0, '0);
        send_request(CMD_CREATE, '0, 48'd10, 32'd5);
        send_request(CMD_ADVANCE, '0, 48'd10, '0);
        send_request(CMD_ADVANCE, '0, 48'd11, '0);
        send_request(CMD_ADVANCE, '0, 48'd15, '0);
        wait_drained();
        write_reg(REG_DEFAULT_WAIT, 16'hFFFF);
        write_reg(REG_MIN_WAIT, 16'hFFFF);
        write_reg(REG_LATE_LIMIT, 16'hFFFF);
        send_request(CMD_ADVANCE, '0, 48'd70000, '0);
        send_request(CMD_ADVANCE, '0, 48'd200000, '0);
        wait_drained();
        clear_table();
        send_request(CMD_ADVANCE, '0, 48'd0, '0);
        wait_drained();
        write_reg(REG_DEFAULT_WAIT, 16'd1234);
        write_reg(REG_MIN_WAIT, 16'd3);
        write_reg(REG_LATE_LIMIT, 16'd20);
    endtask

    // long result hold-off so the block backs up, then a full drain
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (1500) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++) begin
            send_request(CMD_CREATE, '0, 48'(i * 4), 32'(i % 3));
            send_request(CMD_ADVANCE, '0, 48'(i * 4), '0);
        end
        wait_drained();
        clear_table();
    endtask

    task automatic test_random();
        int          pick;
        logic [31:0] per;
        sim_now = '0;
        for (int n = 0; n < 90; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) per = 0;
            else if ($urandom_range(0, 19) == 0) per = $urandom;
            else per = $urandom_range(0, 100);
            if ($urandom_range(0, 2) == 0) per = 0;
            if (pick < 40)
                send_request(CMD_CREATE, 5'($urandom), sim_now + $urandom_range(0, 300), per);
            else if (pick < 60)
                send_request(CMD_CANCEL, 5'($urandom), 48'($urandom), $urandom);
            else if (pick < 95) begin
                sim_now = sim_now + $urandom_range(0, 150);
                if ($urandom_range(0, 15) == 0) sim_now = sim_now + $urandom_range(0, 3000);
                send_request(CMD_ADVANCE, 5'($urandom), sim_now, $urandom);
            end else if (pick < 97)
                send_request(CMD_NONE, 5'($urandom), 48'({$urandom, $urandom}), $urandom);
            else
                send_request(CMD_CREATE, 5'($urandom), 48'({$urandom, $urandom}), $urandom);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < TimerSlots; i++) begin
            tmr_live[i] = 1'b0;
            tmr_deadline[i] = '0;
            tmr_period[i] = '0;
            tmr_silenced[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed();
        test_full_table();
        test_fire_limit();
        test_registers();
        test_backpressure();
        test_random();

        if (err_count == 0)
            $display("tb_periodic_timer_scheduler passed");
        else
            $display("tb_periodic_timer_scheduler failed");
        $finish;
    end

endmodule
